// ----- rtl/csrm_pkg.sv -----
// ============================================================================
// csrm_pkg: shared types and constants for the canary spike rollback monitor
// Action codes, configuration register indexes, sizing of the per-minute
// block counter store and of the timing path.
// ============================================================================
package csrm_pkg;

    // Window geometry
    localparam int NUM_MINUTES   = 10;
    localparam int MS_PER_MINUTE = 60000;
    localparam int MS_PER_SECOND = 1000;

    // Index into the per-minute counter store
    localparam int MIN_W = $clog2(NUM_MINUTES);

    // Widths of the item fields and registers
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int BASE_W      = 16;
    localparam int MULT_W      = 8;
    localparam int STREAK_W    = 8;
    localparam int WINSEC_W    = 16;
    localparam int WINDOW_MS_W = 26;  // 65535 s * 1000 fits in 26 bits
    localparam int PROD_W      = BASE_W + MULT_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MIN_OUT_W   = 4;

    // Register reset values
    localparam logic [WINSEC_W-1:0] WINDOW_SECONDS_RST   = WINSEC_W'(600);
    localparam logic [MULT_W-1:0]   SPIKE_MULTIPLIER_RST = MULT_W'(3);
    localparam logic [STREAK_W-1:0] SPIKE_LIMIT_RST      = STREAK_W'(3);

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    // Item action codes
    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_BLOCK = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_MULTIPLIER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIMIT      = 2'd2;

endpackage

// ----- rtl/csrm_ram.sv -----
// ============================================================================
// csrm_ram: generic simple dual port RAM
// One write port, one read port with a read enable and registered read data.
// A read of the address written in the same cycle returns the old contents.
// ============================================================================
module csrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/canary_spike_rollback_monitor.sv -----
// ============================================================================
// canary_spike_rollback_monitor: canary window spike watch with rollback
// Counts block events per minute of a canary window, ends the window on
// timeout and pulses rollback after a run of spike minutes.
// ============================================================================
// A result beat passes stages a, b, c and d and then the output register.
// Throughput: one beat per cycle; the counter read-modify-write and the
//   state update close in the commit stage, with write forwarding one back.
// The input side stalls only while a result sits in the last stage and the
//   output register is full and not taken.
// Reset: registers take their reset values, the window is inactive, and the
//   counter store reads as zero through per-entry valid bits (no clear pass).
module canary_spike_rollback_monitor
    import csrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [BASE_W-1:0]     new_baseline,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  rollback,
    output logic                  window_active,
    output logic                  window_expired,
    output logic [MIN_OUT_W-1:0]  minute_index,
    output logic [STREAK_W-1:0]   streak_count
);

    // Stage payloads
    typedef struct packed {
        action_t             action;
        logic [TIME_W-1:0]   elapsed;
        logic [BASE_W-1:0]   baseline;
    } stage_a_t;

    typedef struct packed {
        action_t                action;
        logic                   expire;
        logic [NUM_MINUTES-1:0] thermo;
        logic [PROD_W-1:0]      prod;
        logic                   base_nz;
    } stage_b_t;

    typedef struct packed {
        action_t              action;
        logic                 expire;
        logic                 late;
        logic [MIN_W-1:0]     cur;
        logic [MIN_W-1:0]     prev;
        logic [COUNT_W-1:0]   thr;
        logic                 base_nz;
    } stage_c_t;

    typedef struct packed {
        action_t              action;
        logic                 expire;
        logic                 late;
        logic [MIN_W-1:0]     cur;
        logic [COUNT_W-1:0]   thr;
        logic                 base_nz;
        logic                 fwd_hit;
        logic [COUNT_W-1:0]   fwd_data;
        logic                 rd_valid;
    } stage_d_t;

    // Configuration registers
    logic [WINSEC_W-1:0]    window_seconds_reg;
    logic [MULT_W-1:0]      spike_multiplier_reg;
    logic [STREAK_W-1:0]    spike_limit_reg;
    logic [WINDOW_MS_W-1:0] window_ms_reg;

    // Front copies of start time and baseline, updated when a start is accepted
    logic [TIME_W-1:0]      start_time_reg;
    logic [BASE_W-1:0]      baseline_reg;
    logic [BASE_W-1:0]      baseline_seen;

    // Pipeline
    logic                   a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    stage_a_t               a_reg;
    stage_b_t               b_reg;
    stage_c_t               c_reg;
    stage_d_t               d_reg;
    logic [NUM_MINUTES-1:0] thermo_next;
    logic [MIN_W-1:0]       cur_next;

    // Window state
    logic                   active_reg, active_next;
    logic [MIN_W-1:0]       minute_reg, minute_next;
    logic [STREAK_W-1:0]    streak_reg, streak_next;
    logic [NUM_MINUTES-1:0] cnt_valid_reg, cnt_valid_next;

    // Commit stage signals
    logic                   adv;
    logic                   out_free;
    logic                   commit;
    logic                   in_accept;
    logic [COUNT_W-1:0]     ram_q;
    logic [COUNT_W-1:0]     cnt_val;
    logic [COUNT_W-1:0]     cnt_wdata;
    logic                   cnt_we;
    logic                   ram_we;
    logic [MIN_W-1:0]       rd_addr;
    logic [MIN_W-1:0]       minute_after;
    logic [NUM_MINUTES-1:0] valid_after;
    logic                   spike;
    logic [STREAK_W-1:0]    streak_upd;
    logic                   rb_hit;
    logic                   exp_hit;

    // Output register
    logic                   out_valid_reg;
    logic                   rollback_reg;
    logic                   window_active_reg;
    logic                   window_expired_reg;
    logic [MIN_OUT_W-1:0]   minute_index_reg;
    logic [STREAK_W-1:0]    streak_count_reg;

    // Flow control: the pipe moves unless a result is stuck behind a full output
    assign out_free  = !out_valid_reg || out_ready;
    assign adv       = out_free || !d_valid_reg;
    assign in_ready  = adv;
    assign in_accept = in_valid && in_ready;
    assign commit    = adv && d_valid_reg;

    // Configuration registers and derived window length in ms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_seconds_reg   <= WINDOW_SECONDS_RST;
            spike_multiplier_reg <= SPIKE_MULTIPLIER_RST;
            spike_limit_reg      <= SPIKE_LIMIT_RST;
            window_ms_reg        <= WINDOW_MS_W'(WINDOW_SECONDS_RST * MS_PER_SECOND);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW_SECONDS:   window_seconds_reg   <= cfg_data[WINSEC_W-1:0];
                    CFG_SPIKE_MULTIPLIER: spike_multiplier_reg <= cfg_data[MULT_W-1:0];
                    CFG_SPIKE_LIMIT:      spike_limit_reg      <= cfg_data[STREAK_W-1:0];
                    default: ;
                endcase
            end
            window_ms_reg <= WINDOW_MS_W'(window_seconds_reg * MS_PER_SECOND);
        end
    end

    // Baseline as seen by the incoming beat
    assign baseline_seen = (action_t'(action) == ACT_START && new_baseline != '0)
                           ? new_baseline : baseline_reg;

    // Front registers: start time and baseline follow accepted starts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            baseline_reg   <= '0;
        end
        else if (in_accept && action_t'(action) == ACT_START)
        begin
            start_time_reg <= now_ms;
            baseline_reg   <= baseline_seen;
        end
    end

    // Minute boundaries crossed by the elapsed time
    always_comb
    begin
        for (int k = 0; k < NUM_MINUTES; k++)
        begin
            thermo_next[k] = a_reg.elapsed >= TIME_W'((k + 1) * MS_PER_MINUTE);
        end
    end

    assign cur_next = MIN_W'($countones(b_reg.thermo[NUM_MINUTES-2:0]));

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_accept;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Pipeline payload: elapsed time, compares, threshold, read forwarding
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg.action   <= action_t'(action);
            a_reg.elapsed  <= now_ms - start_time_reg;
            a_reg.baseline <= baseline_seen;

            b_reg.action   <= a_reg.action;
            b_reg.expire   <= a_reg.elapsed >= TIME_W'(window_ms_reg);
            b_reg.thermo   <= thermo_next;
            b_reg.prod     <= PROD_W'(a_reg.baseline) * PROD_W'(spike_multiplier_reg);
            b_reg.base_nz  <= a_reg.baseline != '0;

            c_reg.action   <= b_reg.action;
            c_reg.expire   <= b_reg.expire;
            c_reg.late     <= b_reg.thermo[NUM_MINUTES-1];
            c_reg.cur      <= cur_next;
            c_reg.prev     <= (cur_next != '0) ? cur_next - MIN_W'(1) : '0;
            c_reg.thr      <= (b_reg.prod > PROD_W'(COUNT_MAX))
                              ? COUNT_MAX : b_reg.prod[COUNT_W-1:0];
            c_reg.base_nz  <= b_reg.base_nz;

            d_reg.action   <= c_reg.action;
            d_reg.expire   <= c_reg.expire;
            d_reg.late     <= c_reg.late;
            d_reg.cur      <= c_reg.cur;
            d_reg.thr      <= c_reg.thr;
            d_reg.base_nz  <= c_reg.base_nz;
            d_reg.fwd_hit  <= ram_we && (minute_reg == rd_addr);
            d_reg.fwd_data <= cnt_wdata;
            d_reg.rd_valid <= valid_after[rd_addr];
        end
    end

    // Counter read address: previous minute for a tick, live minute otherwise
    assign minute_after = commit ? minute_next : minute_reg;
    assign valid_after  = commit ? cnt_valid_next : cnt_valid_reg;
    assign rd_addr      = (c_reg.action == ACT_TICK) ? c_reg.prev : minute_after;
    assign ram_we       = commit && cnt_we;

    csrm_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_MINUTES)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (minute_reg),
        .wdata (cnt_wdata),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // Counter value with forwarding and never-written entries as zero
    assign cnt_val   = d_reg.fwd_hit  ? d_reg.fwd_data :
                       d_reg.rd_valid ? ram_q : '0;
    assign cnt_wdata = (cnt_val != COUNT_MAX) ? cnt_val + COUNT_W'(1) : cnt_val;

    // Spike decision on the previous minute
    assign spike      = (cnt_val > d_reg.thr) && d_reg.base_nz;
    assign streak_upd = spike ? ((streak_reg != STREAK_MAX) ? streak_reg + STREAK_W'(1)
                                                            : streak_reg)
                              : '0;

    // Commit: window state update
    always_comb
    begin
        active_next    = active_reg;
        minute_next    = minute_reg;
        streak_next    = streak_reg;
        cnt_valid_next = cnt_valid_reg;
        cnt_we         = 1'b0;
        rb_hit         = 1'b0;
        exp_hit        = 1'b0;
        case (d_reg.action)
            ACT_START:
            begin
                active_next    = 1'b1;
                minute_next    = '0;
                streak_next    = '0;
                cnt_valid_next = '0;
            end
            ACT_TICK:
            begin
                if (active_reg)
                begin
                    if (d_reg.expire)
                    begin
                        active_next = 1'b0;
                        exp_hit     = 1'b1;
                    end
                    else if (!d_reg.late && d_reg.cur != minute_reg)
                    begin
                        minute_next = d_reg.cur;
                        streak_next = streak_upd;
                        if (streak_upd >= spike_limit_reg)
                        begin
                            active_next = 1'b0;
                            rb_hit      = 1'b1;
                        end
                    end
                end
            end
            ACT_BLOCK:
            begin
                if (active_reg)
                begin
                    cnt_we                     = 1'b1;
                    cnt_valid_next[minute_reg] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Window state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            minute_reg    <= '0;
            streak_reg    <= '0;
            cnt_valid_reg <= '0;
        end
        else if (commit)
        begin
            active_reg    <= active_next;
            minute_reg    <= minute_next;
            streak_reg    <= streak_next;
            cnt_valid_reg <= cnt_valid_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            rollback_reg       <= rb_hit;
            window_active_reg  <= active_next;
            window_expired_reg <= exp_hit;
            minute_index_reg   <= MIN_OUT_W'(minute_next);
            streak_count_reg   <= streak_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign rollback       = rollback_reg;
    assign window_active  = window_active_reg;
    assign window_expired = window_expired_reg;
    assign minute_index   = minute_index_reg;
    assign streak_count   = streak_count_reg;

endmodule

// ----- rtl/csrm_checker.sv -----
// ============================================================================
// csrm_checker: port-level checks for the canary spike rollback monitor
// Watches the handshakes and result beats and flags inconsistent results.
// ============================================================================
module csrm_checker
    import csrm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 rollback,
    input  logic                 window_active,
    input  logic                 window_expired,
    input  logic [MIN_OUT_W-1:0] minute_index,
    input  logic [STREAK_W-1:0]  streak_count
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rollback)
            && $stable(window_active) && $stable(window_expired)
            && $stable(minute_index) && $stable(streak_count))
        else $error("result beat changed while stalled");

    // Rollback closes the window
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rollback |-> !window_active)
        else $error("rollback with window still active");

    // Timeout closes the window and never comes with rollback
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_expired |-> !window_active && !rollback)
        else $error("expiry beat inconsistent");

    // Input side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free output");

endmodule

bind canary_spike_rollback_monitor csrm_checker u_csrm_checker (.*);
